// ===== sv/nrmc_pkg.sv =====
package nrmc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TZ_W     = 5;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned TIME_W   = 7;
    localparam int unsigned FIELD_W  = 4;
    localparam int unsigned CHAR_W   = 3;
    localparam int unsigned GDIG_W   = 2;

    localparam logic [BYTE_W-1:0]  CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0]  CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0]  CH_A     = 8'h41;
    localparam logic [FIELD_W-1:0] FIELD_MAX    = 4'd15;
    localparam logic [FIELD_W-1:0] FIELD_MIN    = 4'd12;
    localparam logic [CHAR_W-1:0]  CHAR_MAX     = 3'd7;
    localparam logic [CHAR_W-1:0]  HDR_LEN      = 3'd6;
    localparam logic [CHAR_W-1:0]  TIME_DIGITS  = 3'd6;
    localparam logic [GDIG_W-1:0]  SUM_DIGITS   = 2'd2;
    localparam logic [GDIG_W-1:0]  SUM_TOO_LONG = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_NOT_RMC   = 3'd1,
        ST_NOT_VALID = 3'd2,
        ST_CKSUM_BAD = 3'd3,
        ST_MALFORMED = 3'd4
    } t_status;

    // Sentence state as it stands after the byte that ends a sentence.
    typedef struct packed {
        logic                header_match;
        logic                status_match;
        logic [FIELD_W-1:0]  field_number;
        logic                past_star;
        logic [GDIG_W-1:0]   given_digits;
        logic [BYTE_W-1:0]   given_sum;
        logic [BYTE_W-1:0]   xor_sum;
        logic [CHAR_W-1:0]   time_digit_count;
        logic [TIME_W-1:0]   utc_hour;
        logic [TIME_W-1:0]   utc_minute;
        logic [TIME_W-1:0]   utc_second;
    } t_summary;

    function automatic logic [BYTE_W-1:0] hdr_char(input logic [CHAR_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [4:0] res;
        if (c inside {[8'h30:8'h39]}) begin
            res = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            res = {1'b1, 4'(c[3:0] + 4'd9)};
        end else begin
            res = 5'd0;
        end
        return res;
    endfunction

endpackage

// ===== sv/nrmc_parse.sv =====
module nrmc_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [nrmc_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    output nrmc_pkg::t_summary         o_summary
);

    logic                          r_at_first, n_at_first;
    logic [nrmc_pkg::FIELD_W-1:0]  r_field, n_field;
    logic [nrmc_pkg::CHAR_W-1:0]   r_char, n_char;
    logic                          r_hdr_ok, n_hdr_ok;
    logic                          r_stat_ok, n_stat_ok;
    logic [nrmc_pkg::BYTE_W-1:0]   r_xor, n_xor;
    logic                          r_past_star, n_past_star;
    logic [nrmc_pkg::BYTE_W-1:0]   r_gsum, n_gsum;
    logic [nrmc_pkg::GDIG_W-1:0]   r_gdig, n_gdig;
    logic [nrmc_pkg::CHAR_W-1:0]   r_tdc, n_tdc;
    logic [nrmc_pkg::TIME_W-1:0]   r_hour, n_hour;
    logic [nrmc_pkg::TIME_W-1:0]   r_min, n_min;
    logic [nrmc_pkg::TIME_W-1:0]   r_sec, n_sec;

    always_comb begin
        logic [4:0]  hex;
        logic        is_digit;
        logic [3:0]  dval;
        logic [10:0] acc;
        hex      = nrmc_pkg::hex_value(i_byte);
        is_digit = (i_byte inside {[8'h30:8'h39]});
        dval     = i_byte[3:0];
        acc      = 11'd0;

        n_at_first  = 1'b0;
        n_field     = r_field;
        n_char      = r_char;
        n_hdr_ok    = r_hdr_ok;
        n_stat_ok   = r_stat_ok;
        n_xor       = r_xor;
        n_past_star = r_past_star;
        n_gsum      = r_gsum;
        n_gdig      = r_gdig;
        n_tdc       = r_tdc;
        n_hour      = r_hour;
        n_min       = r_min;
        n_sec       = r_sec;

        if (r_past_star) begin
            if (hex[4] && ({1'b0, r_gdig} == r_char)) begin
                if (r_gdig < nrmc_pkg::SUM_DIGITS) begin
                    n_gsum = {r_gsum[3:0], hex[3:0]};
                    n_gdig = r_gdig + 2'd1;
                end else begin
                    n_gdig = nrmc_pkg::SUM_TOO_LONG;
                end
            end
            if (r_char < nrmc_pkg::CHAR_MAX) n_char = r_char + 3'd1;
        end else if (i_byte == nrmc_pkg::CH_STAR && !r_at_first) begin
            if (r_field == 4'd0 && r_char != nrmc_pkg::HDR_LEN) n_hdr_ok = 1'b0;
            if (r_field == 4'd2 && r_char != 3'd1) n_stat_ok = 1'b0;
            n_past_star = 1'b1;
            n_char      = 3'd0;
        end else begin
            if (!r_at_first) n_xor = r_xor ^ i_byte;
            if (i_byte == nrmc_pkg::CH_COMMA) begin
                if (r_field == 4'd0 && r_char != nrmc_pkg::HDR_LEN) n_hdr_ok = 1'b0;
                if (r_field == 4'd2 && r_char != 3'd1) n_stat_ok = 1'b0;
                if (r_field < nrmc_pkg::FIELD_MAX) n_field = r_field + 4'd1;
                n_char = 3'd0;
            end else begin
                if (r_field == 4'd0) begin
                    if (r_char >= nrmc_pkg::HDR_LEN || i_byte != nrmc_pkg::hdr_char(r_char))
                        n_hdr_ok = 1'b0;
                end else if (r_field == 4'd1) begin
                    if (is_digit && r_tdc == r_char && r_tdc < nrmc_pkg::TIME_DIGITS) begin
                        if (r_tdc < 3'd2) begin
                            acc    = 11'(r_hour) * 11'd10 + 11'(dval);
                            n_hour = acc[6:0];
                        end else if (r_tdc < 3'd4) begin
                            acc   = 11'(r_min) * 11'd10 + 11'(dval);
                            n_min = acc[6:0];
                        end else begin
                            acc   = 11'(r_sec) * 11'd10 + 11'(dval);
                            n_sec = acc[6:0];
                        end
                        n_tdc = r_tdc + 3'd1;
                    end
                end else if (r_field == 4'd2) begin
                    if (r_char >= 3'd1 || i_byte != nrmc_pkg::CH_A) n_stat_ok = 1'b0;
                end
                if (r_char < nrmc_pkg::CHAR_MAX) n_char = r_char + 3'd1;
            end
        end

        // A field still open at the last byte is length-checked as if closed.
        if (i_last && !n_past_star) begin
            if (n_field == 4'd0 && n_char != nrmc_pkg::HDR_LEN) n_hdr_ok = 1'b0;
            if (n_field == 4'd2 && n_char != 3'd1) n_stat_ok = 1'b0;
        end

        o_summary.header_match     = n_hdr_ok;
        o_summary.status_match     = n_stat_ok;
        o_summary.field_number     = n_field;
        o_summary.past_star        = n_past_star;
        o_summary.given_digits     = n_gdig;
        o_summary.given_sum        = n_gsum;
        o_summary.xor_sum          = n_xor;
        o_summary.time_digit_count = n_tdc;
        o_summary.utc_hour         = n_hour;
        o_summary.utc_minute       = n_min;
        o_summary.utc_second       = n_sec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_at_first  <= 1'b1;
            r_field     <= '0;
            r_char      <= '0;
            r_hdr_ok    <= 1'b1;
            r_stat_ok   <= 1'b1;
            r_xor       <= '0;
            r_past_star <= 1'b0;
            r_gsum      <= '0;
            r_gdig      <= '0;
            r_tdc       <= '0;
            r_hour      <= '0;
            r_min       <= '0;
            r_sec       <= '0;
        end else if (i_step) begin
            r_at_first  <= n_at_first;
            r_field     <= n_field;
            r_char      <= n_char;
            r_hdr_ok    <= n_hdr_ok;
            r_stat_ok   <= n_stat_ok;
            r_xor       <= n_xor;
            r_past_star <= n_past_star;
            r_gsum      <= n_gsum;
            r_gdig      <= n_gdig;
            r_tdc       <= n_tdc;
            r_hour      <= n_hour;
            r_min       <= n_min;
            r_sec       <= n_sec;
        end
    end

endmodule

// ===== sv/nrmc_result.sv =====
module nrmc_result (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  nrmc_pkg::t_summary            i_summary,
    input  logic [nrmc_pkg::TZ_W-1:0]     i_tz,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [nrmc_pkg::STAT_W-1:0]   o_status,
    output logic [nrmc_pkg::HOUR_W-1:0]   o_local_hour,
    output logic [nrmc_pkg::TIME_W-1:0]   o_minute,
    output logic [nrmc_pkg::TIME_W-1:0]   o_second
);

    logic                          r_valid, n_valid;
    nrmc_pkg::t_status             r_status, n_status;
    logic [nrmc_pkg::HOUR_W-1:0]   r_hour, n_hour;
    logic [nrmc_pkg::TIME_W-1:0]   r_min, n_min;
    logic [nrmc_pkg::TIME_W-1:0]   r_sec, n_sec;

    logic [7:0] hour_sum;
    logic [4:0] eighths;
    logic [8:0] q_prod;
    logic [4:0] eighths_mod3;

    // x mod 24 = 8 * ((x / 8) mod 3) + (x mod 8); x / 8 stays below 32, where
    // (n * 11) >> 5 equals n / 3.
    assign hour_sum     = 8'(i_summary.utc_hour) + 8'(i_tz);
    assign eighths      = hour_sum[7:3];
    assign q_prod       = 9'(eighths) * 9'd11;
    assign eighths_mod3 = eighths - 5'(q_prod[8:5]) * 5'd3;

    always_comb begin
        if (!i_summary.header_match) begin
            n_status = nrmc_pkg::ST_NOT_RMC;
        end else if (i_summary.field_number < nrmc_pkg::FIELD_MIN || !i_summary.past_star
                     || i_summary.given_digits == 2'd0) begin
            n_status = nrmc_pkg::ST_MALFORMED;
        end else if (!i_summary.status_match) begin
            n_status = nrmc_pkg::ST_NOT_VALID;
        end else if (i_summary.given_digits == nrmc_pkg::SUM_TOO_LONG
                     || i_summary.given_sum != i_summary.xor_sum) begin
            n_status = nrmc_pkg::ST_CKSUM_BAD;
        end else if (i_summary.time_digit_count < nrmc_pkg::TIME_DIGITS) begin
            n_status = nrmc_pkg::ST_MALFORMED;
        end else begin
            n_status = nrmc_pkg::ST_ACCEPTED;
        end

        if (n_status == nrmc_pkg::ST_ACCEPTED) begin
            n_hour = {eighths_mod3[1:0], hour_sum[2:0]};
            n_min  = i_summary.utc_minute;
            n_sec  = i_summary.utc_second;
        end else begin
            n_hour = '0;
            n_min  = '0;
            n_sec  = '0;
        end

        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= n_status;
            r_hour   <= n_hour;
            r_min    <= n_min;
            r_sec    <= n_sec;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_local_hour = r_hour;
    assign o_minute     = r_min;
    assign o_second     = r_sec;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || !i_stall))
        else $error("result register overwritten while stalled");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_hour < 5'd24))
        else $error("local hour out of range");

    a_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != nrmc_pkg::ST_ACCEPTED)
        |-> (r_hour == '0 && r_min == '0 && r_sec == '0))
        else $error("time fields not cleared on a rejected sentence");

    a_status_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_status == $past(n_status)))
        else $error("status not captured");

endmodule

// ===== sv/nmea_rmc_sentence_checker_core.sv =====
// NMEA RMC sentence checker.
// Input channel: one sentence character per transfer on i_in_byte, with
// i_last_byte high on its final character; i_valid / o_stall handshake.
// Output channel: one result per sentence (o_status, o_local_hour, o_minute,
// o_second) on o_valid / i_stall. Characters other than the last give no result.
// Status codes: 0 accepted, 1 not GPRMC, 2 not valid, 3 checksum mismatch,
// 4 malformed. Time fields read zero unless the status is accepted.
// Configuration: i_cfg_we writes i_cfg_data into the timezone offset (reset 8);
// write it only while no sentence is in flight.
// A character is registered in the input register on its transfer and then
// taken by the sentence state update, which loads a last character's result
// into the result register. Throughput is one character per cycle, set by the
// input register feeding the state update, save when a last character stalls.
// When the receiver stalls, the result holds and characters other than the
// last keep flowing; a last character waits in the input register, with
// o_stall high, until the result register frees.
// Reset (synchronous, active low) clears the sentence state, empties both
// registers and sets the offset back to 8.
module nmea_rmc_sentence_checker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nrmc_pkg::TZ_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [nrmc_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_last_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nrmc_pkg::STAT_W-1:0]   o_status,
    output logic [nrmc_pkg::HOUR_W-1:0]   o_local_hour,
    output logic [nrmc_pkg::TIME_W-1:0]   o_minute,
    output logic [nrmc_pkg::TIME_W-1:0]   o_second
);

    logic [nrmc_pkg::TZ_W-1:0]    r_tz_hours;
    logic                         r_in_valid, n_in_valid;
    logic [nrmc_pkg::BYTE_W-1:0]  r_in_byte;
    logic                         r_in_last;
    logic                         step;
    logic                         accept;
    logic                         res_valid;
    nrmc_pkg::t_summary           summary;

    // A last character needs the result register to be free or draining.
    assign step   = r_in_valid && (!r_in_last || !res_valid || !i_stall);
    assign accept = i_valid && !o_stall;
    assign o_stall = r_in_valid && !step;

    always_comb begin
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_tz_hours <= 5'd8;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) r_tz_hours <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_last_byte;
        end
    end

    nrmc_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_summary (summary)
    );

    nrmc_result u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (step && r_in_last),
        .i_summary    (summary),
        .i_tz         (r_tz_hours),
        .i_stall      (i_stall),
        .o_valid      (res_valid),
        .o_status     (o_status),
        .o_local_hour (o_local_hour),
        .o_minute     (o_minute),
        .o_second     (o_second)
    );

    assign o_valid = res_valid;

    a_mid_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> !o_stall)
        else $error("input stalled on a character that gives no result");

endmodule
